/* hw/rtl/cdo_pkg.sv */
// ----------------------------------------------------------------------------
// cdo_pkg
// Shared widths, calendar constants and control types of the date offset unit.
// ----------------------------------------------------------------------------
package cdo_pkg;

   // field widths
   localparam int OFFSET_WIDTH = 21;
   localparam int YEAR_W       = 14;
   localparam int MONTH_W      = 4;
   localparam int DAY_W        = 5;

   // internal widths
   localparam int YP_W    = 15;
   localparam int Q25_W   = 8;
   localparam int COUNT_W = 23;
   localparam int T_W     = ((OFFSET_WIDTH > COUNT_W) ? OFFSET_WIDTH : COUNT_W) + 2;
   localparam int Z_W     = 22;
   localparam int REM_W   = 19;
   localparam int DOE_W   = 18;
   localparam int ERA_W   = 5;
   localparam int YOE_W   = 9;
   localparam int DOY_W   = 9;
   localparam int MP_W    = 4;

   // calendar constants
   localparam int DAYS_YEAR  = 365;
   localparam int YEAR_SHIFT = 400;
   localparam int ERA_DAYS   = 146097;
   localparam int CENT_DAYS  = 36524;
   localparam int QUAD_DAYS  = 1460;
   localparam int YEAR_MAX   = 9999;
   localparam int MONTH_MAX  = 12;
   localparam int DAY_MAX    = 31;

   localparam logic signed [T_W-1:0] LO_COUNT = T_W'(146037);
   localparam logic signed [T_W-1:0] HI_COUNT = T_W'(3798461);

   // reciprocal multipliers for division by constants
   localparam int DIV25_RECIP  = 2622;
   localparam int DIV25_SHIFT  = 16;
   localparam int INV25        = 3113;
   localparam int MULT25_LIMIT = 163;
   localparam int ERA_RECIP    = 1837;
   localparam int ERA_SHIFT    = 28;
   localparam int ERA_PROD_W   = 33;
   localparam int QUAD_RECIP   = 183861;
   localparam int QUAD_SHIFT   = 28;
   localparam int YEAR_RECIP   = 183861;
   localparam int YEAR_RSHIFT  = 26;
   localparam int RECIP_PROD_W = 36;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCALE,
      ST_BASE,
      ST_SHIFT,
      ST_BOUND,
      ST_ERA,
      ST_ERA_REM,
      ST_ERA_FIX,
      ST_YEAR_A,
      ST_YEAR_B,
      ST_YEAR_C,
      ST_DOY,
      ST_MONTH,
      ST_DATE,
      ST_FINISH
   } cdo_state_type;

   typedef struct packed {
      logic capture;
      logic check;
      logic scale;
      logic base;
      logic shift;
      logic bound;
      logic era;
      logic era_rem;
      logic era_fix;
      logic year_a;
      logic year_b;
      logic year_c;
      logic doy;
      logic month;
      logic date;
      logic put;
   } cdo_cmd_type;

   typedef struct packed {
      logic date_ok;
   } cdo_status_type;

endpackage

/* hw/rtl/cdo_req_if.sv */
// ----------------------------------------------------------------------------
// cdo_req_if
// Request channel of the date offset unit: start date and signed day offset.
// ----------------------------------------------------------------------------
interface cdo_req_if import cdo_pkg::*; ();

   logic                           valid;
   logic                           ready;
   logic        [YEAR_W-1:0]       in_year;
   logic        [MONTH_W-1:0]      in_month;
   logic        [DAY_W-1:0]        in_day;
   logic signed [OFFSET_WIDTH-1:0] offset_days;

   modport source (
      output valid, in_year, in_month, in_day, offset_days,
      input  ready
   );

   modport sink (
      input  valid, in_year, in_month, in_day, offset_days,
      output ready
   );

endinterface

/* hw/rtl/cdo_rsp_if.sv */
// ----------------------------------------------------------------------------
// cdo_rsp_if
// Response channel of the date offset unit: resulting date and status flags.
// ----------------------------------------------------------------------------
interface cdo_rsp_if import cdo_pkg::*; ();

   logic               valid;
   logic               ready;
   logic [YEAR_W-1:0]  out_year;
   logic [MONTH_W-1:0] out_month;
   logic [DAY_W-1:0]   out_day;
   logic               date_ok;
   logic               year_clamped;

   modport source (
      output valid, out_year, out_month, out_day, date_ok, year_clamped,
      input  ready
   );

   modport sink (
      input  valid, out_year, out_month, out_day, date_ok, year_clamped,
      output ready
   );

endinterface

/* hw/rtl/cdo_datapath.sv */
// ----------------------------------------------------------------------------
// cdo_datapath
// Date check, day count, offset add, range clamp and count-to-date conversion,
// one step per command from the controller.
// ----------------------------------------------------------------------------
module cdo_datapath import cdo_pkg::*; (
   input  logic                           clock,
   input  cdo_cmd_type                    cmd,
   output cdo_status_type                 status,
   input  logic        [YEAR_W-1:0]       in_year,
   input  logic        [MONTH_W-1:0]      in_month,
   input  logic        [DAY_W-1:0]        in_day,
   input  logic signed [OFFSET_WIDTH-1:0] offset_days,
   output logic        [YEAR_W-1:0]       out_year,
   output logic        [MONTH_W-1:0]      out_month,
   output logic        [DAY_W-1:0]        out_day,
   output logic                           date_ok,
   output logic                           year_clamped
);

   // true when x is a multiple of 25, for any 12-bit x
   function automatic logic is_mult25(input logic [11:0] x);
      logic [23:0] p;
      p = {12'b0, x} * 24'(INV25);
      return p[11:0] <= 12'(MULT25_LIMIT);
   endfunction

   // floor(x / 25) for x below 4681
   function automatic logic [Q25_W-1:0] div25(input logic [12:0] x);
      logic [24:0] p;
      p = {12'b0, x} * 25'(DIV25_RECIP);
      return p[DIV25_SHIFT +: Q25_W];
   endfunction

   // first day of each month, counted from march 1
   function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
      logic [DOY_W-1:0] s;
      case (mp)
         4'd0:    s = DOY_W'(0);
         4'd1:    s = DOY_W'(31);
         4'd2:    s = DOY_W'(61);
         4'd3:    s = DOY_W'(92);
         4'd4:    s = DOY_W'(122);
         4'd5:    s = DOY_W'(153);
         4'd6:    s = DOY_W'(184);
         4'd7:    s = DOY_W'(214);
         4'd8:    s = DOY_W'(245);
         4'd9:    s = DOY_W'(275);
         4'd10:   s = DOY_W'(306);
         4'd11:   s = DOY_W'(337);
         default: s = DOY_W'(0);
      endcase
      return s;
   endfunction

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
      logic [DAY_W-1:0] n;
      case (m)
         4'd2:                      n = leap ? DAY_W'(29) : DAY_W'(28);
         4'd4, 4'd6, 4'd9, 4'd11:   n = DAY_W'(30);
         4'd1, 4'd3, 4'd5, 4'd7,
         4'd8, 4'd10, 4'd12:        n = DAY_W'(31);
         default:                   n = DAY_W'(0);
      endcase
      return n;
   endfunction

   // captured request
   logic        [YEAR_W-1:0]       year_ff;
   logic        [MONTH_W-1:0]      month_ff;
   logic        [DAY_W-1:0]        day_ff;
   logic signed [OFFSET_WIDTH-1:0] offset_ff;

   // date to count
   logic                   ok_ff;
   logic [YP_W-1:0]        yp_ff;
   logic [DOY_W-1:0]       start_doy_ff;
   logic [Q25_W-1:0]       q100_ff;
   logic [Q25_W-1:0]       q400_ff;
   logic [COUNT_W-1:0]     y365_ff;
   logic [COUNT_W-1:0]     base_ff;
   logic signed [T_W-1:0]  t_ff;
   logic                   under_ff;
   logic                   over_ff;
   logic [Z_W-1:0]         z_ff;

   // count to date
   logic [ERA_W-1:0]       era_est_ff;
   logic [REM_W-1:0]       rem_ff;
   logic [ERA_W-1:0]       era_ff;
   logic [DOE_W-1:0]       doe_ff;
   logic [6:0]             q1460_ff;
   logic [2:0]             q36524_ff;
   logic                   last_ff;
   logic [DOE_W-1:0]       a_ff;
   logic [YOE_W-1:0]       yoe_ff;
   logic [DOY_W-1:0]       res_doy_ff;
   logic [MP_W-1:0]        mp_ff;
   logic [YEAR_W-1:0]      ybase_ff;
   logic [YEAR_W-1:0]      date_year_ff;
   logic [MONTH_W-1:0]     date_month_ff;
   logic [DAY_W-1:0]       date_day_ff;

   // response register
   logic [YEAR_W-1:0]      out_year_ff;
   logic [MONTH_W-1:0]     out_month_ff;
   logic [DAY_W-1:0]       out_day_ff;
   logic                   date_ok_ff;
   logic                   year_clamped_ff;

   // check step
   logic                   early_c;
   logic                   leap_c;
   logic [MP_W-1:0]        mp_c;

   // conversion helpers
   logic [ERA_PROD_W-1:0]   era_prod_c;
   logic [RECIP_PROD_W-1:0] quad_prod_c;
   logic [RECIP_PROD_W-1:0] year_prod_c;
   logic [1:0]              cent_c;
   logic [DOE_W-1:0]        yday_c;
   logic [MP_W-1:0]         mp_count_c;
   logic                    jan_feb_c;

   always_comb begin
      early_c = month_ff <= MONTH_W'(2);
      leap_c  = (year_ff[1:0] == 2'b00) &&
                (!is_mult25(year_ff[YEAR_W-1:2]) ||
                 ((year_ff[3:0] == 4'b0000) && is_mult25({2'b00, year_ff[YEAR_W-1:4]})));
      mp_c    = early_c ? month_ff + MP_W'(9) : month_ff - MP_W'(3);

      era_prod_c  = ERA_PROD_W'(z_ff) * ERA_PROD_W'(ERA_RECIP);
      quad_prod_c = RECIP_PROD_W'(doe_ff) * RECIP_PROD_W'(QUAD_RECIP);
      year_prod_c = RECIP_PROD_W'(a_ff) * RECIP_PROD_W'(YEAR_RECIP);

      cent_c = 2'(yoe_ff >= YOE_W'(100)) + 2'(yoe_ff >= YOE_W'(200)) +
               2'(yoe_ff >= YOE_W'(300));
      yday_c = DOE_W'(yoe_ff) * DOE_W'(DAYS_YEAR) + DOE_W'(yoe_ff[YOE_W-1:2]) -
               DOE_W'(cent_c);

      mp_count_c = '0;
      for (int k = 1; k < 12; k++) begin
         mp_count_c = mp_count_c + MP_W'(res_doy_ff >= month_start(MP_W'(k)));
      end

      jan_feb_c = mp_ff >= MP_W'(10);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         year_ff   <= in_year;
         month_ff  <= in_month;
         day_ff    <= in_day;
         offset_ff <= offset_days;
      end
      if (cmd.check) begin
         ok_ff        <= (day_ff != '0) && (day_ff <= month_len(month_ff, leap_c));
         yp_ff        <= YP_W'(year_ff) + YP_W'(YEAR_SHIFT) - YP_W'(early_c);
         start_doy_ff <= month_start(mp_c) + DOY_W'(day_ff) - DOY_W'(1);
      end
      if (cmd.scale) begin
         q100_ff <= div25(yp_ff[YP_W-1:2]);
         q400_ff <= div25({2'b00, yp_ff[YP_W-1:4]});
         y365_ff <= COUNT_W'(yp_ff) * COUNT_W'(DAYS_YEAR);
      end
      if (cmd.base) begin
         base_ff <= y365_ff + COUNT_W'(yp_ff[YP_W-1:2]) - COUNT_W'(q100_ff) +
                    COUNT_W'(q400_ff) + COUNT_W'(start_doy_ff);
      end
      if (cmd.shift) begin
         t_ff <= $signed(T_W'(base_ff)) + T_W'(offset_ff);
      end
      if (cmd.bound) begin
         under_ff <= t_ff < LO_COUNT;
         over_ff  <= t_ff > HI_COUNT;
         z_ff     <= t_ff[Z_W-1:0];
      end
      if (cmd.era) begin
         era_est_ff <= era_prod_c[ERA_SHIFT +: ERA_W];
      end
      if (cmd.era_rem) begin
         rem_ff <= REM_W'(z_ff - Z_W'(era_est_ff) * Z_W'(ERA_DAYS));
      end
      if (cmd.era_fix) begin
         if (rem_ff >= REM_W'(ERA_DAYS)) begin
            era_ff <= era_est_ff + ERA_W'(1);
            doe_ff <= DOE_W'(rem_ff - REM_W'(ERA_DAYS));
         end else begin
            era_ff <= era_est_ff;
            doe_ff <= DOE_W'(rem_ff);
         end
      end
      if (cmd.year_a) begin
         q1460_ff  <= quad_prod_c[QUAD_SHIFT +: 7];
         q36524_ff <= 3'(doe_ff >= DOE_W'(CENT_DAYS)) +
                      3'(doe_ff >= DOE_W'(2 * CENT_DAYS)) +
                      3'(doe_ff >= DOE_W'(3 * CENT_DAYS)) +
                      3'(doe_ff >= DOE_W'(4 * CENT_DAYS));
         last_ff   <= doe_ff == DOE_W'(ERA_DAYS - 1);
      end
      if (cmd.year_b) begin
         a_ff <= doe_ff - DOE_W'(q1460_ff) + DOE_W'(q36524_ff) - DOE_W'(last_ff);
      end
      if (cmd.year_c) begin
         yoe_ff <= year_prod_c[YEAR_RSHIFT +: YOE_W];
      end
      if (cmd.doy) begin
         res_doy_ff <= DOY_W'(doe_ff - yday_c);
      end
      if (cmd.month) begin
         mp_ff    <= mp_count_c;
         ybase_ff <= YEAR_W'(yoe_ff) + YEAR_W'(era_ff) * YEAR_W'(YEAR_SHIFT);
      end
      if (cmd.date) begin
         date_day_ff   <= DAY_W'(res_doy_ff - month_start(mp_ff) + DOY_W'(1));
         date_month_ff <= jan_feb_c ? mp_ff - MONTH_W'(9) : mp_ff + MONTH_W'(3);
         date_year_ff  <= ybase_ff + YEAR_W'(jan_feb_c) - YEAR_W'(YEAR_SHIFT);
      end
      if (cmd.put) begin
         if (!ok_ff) begin
            out_year_ff     <= year_ff;
            out_month_ff    <= month_ff;
            out_day_ff      <= day_ff;
            date_ok_ff      <= 1'b0;
            year_clamped_ff <= 1'b0;
         end else if (under_ff) begin
            out_year_ff     <= '0;
            out_month_ff    <= MONTH_W'(1);
            out_day_ff      <= DAY_W'(1);
            date_ok_ff      <= 1'b1;
            year_clamped_ff <= 1'b1;
         end else if (over_ff) begin
            out_year_ff     <= YEAR_W'(YEAR_MAX);
            out_month_ff    <= MONTH_W'(MONTH_MAX);
            out_day_ff      <= DAY_W'(DAY_MAX);
            date_ok_ff      <= 1'b1;
            year_clamped_ff <= 1'b1;
         end else begin
            out_year_ff     <= date_year_ff;
            out_month_ff    <= date_month_ff;
            out_day_ff      <= date_day_ff;
            date_ok_ff      <= 1'b1;
            year_clamped_ff <= 1'b0;
         end
      end
   end

   assign status.date_ok = ok_ff;

   assign out_year     = out_year_ff;
   assign out_month    = out_month_ff;
   assign out_day      = out_day_ff;
   assign date_ok      = date_ok_ff;
   assign year_clamped = year_clamped_ff;

endmodule

/* hw/rtl/cdo_controller.sv */
// ----------------------------------------------------------------------------
// cdo_controller
// Sequencer of the date offset unit: request and response handshakes and the
// step commands for the datapath.
// ----------------------------------------------------------------------------
module cdo_controller import cdo_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output cdo_cmd_type    cmd,
   input  cdo_status_type status
);

   cdo_state_type state_ff;
   cdo_state_type state_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic          slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_valid) state_in = ST_CHECK;
         ST_CHECK:   state_in = ST_SCALE;
         ST_SCALE:   state_in = status.date_ok ? ST_BASE : ST_FINISH;
         ST_BASE:    state_in = ST_SHIFT;
         ST_SHIFT:   state_in = ST_BOUND;
         ST_BOUND:   state_in = ST_ERA;
         ST_ERA:     state_in = ST_ERA_REM;
         ST_ERA_REM: state_in = ST_ERA_FIX;
         ST_ERA_FIX: state_in = ST_YEAR_A;
         ST_YEAR_A:  state_in = ST_YEAR_B;
         ST_YEAR_B:  state_in = ST_YEAR_C;
         ST_YEAR_C:  state_in = ST_DOY;
         ST_DOY:     state_in = ST_MONTH;
         ST_MONTH:   state_in = ST_DATE;
         ST_DATE:    state_in = ST_FINISH;
         ST_FINISH:  if (slot_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_CHECK:   cmd.check   = 1'b1;
         ST_SCALE:   cmd.scale   = 1'b1;
         ST_BASE:    cmd.base    = 1'b1;
         ST_SHIFT:   cmd.shift   = 1'b1;
         ST_BOUND:   cmd.bound   = 1'b1;
         ST_ERA:     cmd.era     = 1'b1;
         ST_ERA_REM: cmd.era_rem = 1'b1;
         ST_ERA_FIX: cmd.era_fix = 1'b1;
         ST_YEAR_A:  cmd.year_a  = 1'b1;
         ST_YEAR_B:  cmd.year_b  = 1'b1;
         ST_YEAR_C:  cmd.year_c  = 1'b1;
         ST_DOY:     cmd.doy     = 1'b1;
         ST_MONTH:   cmd.month   = 1'b1;
         ST_DATE:    cmd.date    = 1'b1;
         ST_FINISH:  cmd.put     = slot_free;
         default:    cmd         = '0;
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.put) begin
         rsp_valid_in = 1'b1;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* hw/rtl/calendar_date_offset.sv */
// ----------------------------------------------------------------------------
// calendar_date_offset
// Gregorian date plus signed day offset, with date check and year saturation.
// ----------------------------------------------------------------------------
// One request at a time. A valid date passes 14 datapath steps (day count,
// offset add, range check, then count-to-date through 400-year cycles by
// reciprocal multiplication), the response load, which waits while the
// previous response is untaken, and the return to idle. An invalid date is
// echoed after the check and scale steps. The time does not depend on the
// offset. The response register lets the next request in while a response
// is still waiting to be taken.
module calendar_date_offset import cdo_pkg::*; (
   input logic       clock,
   input logic       reset,
   cdo_req_if.sink   req_ch,
   cdo_rsp_if.source rsp_ch
);

   cdo_cmd_type    cmd;
   cdo_status_type status;

   cdo_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .status    (status)
   );

   cdo_datapath u_dp (
      .clock        (clock),
      .cmd          (cmd),
      .status       (status),
      .in_year      (req_ch.in_year),
      .in_month     (req_ch.in_month),
      .in_day       (req_ch.in_day),
      .offset_days  (req_ch.offset_days),
      .out_year     (rsp_ch.out_year),
      .out_month    (rsp_ch.out_month),
      .out_day      (rsp_ch.out_day),
      .date_ok      (rsp_ch.date_ok),
      .year_clamped (rsp_ch.year_clamped)
   );

endmodule
